/* hw/rtl/hcf_pkg.sv */
`default_nettype none

package hcf_pkg;

  // Field widths
  localparam int unsigned SHARP_W = 16;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned STEP_W  = 10;
  localparam int unsigned DHF_W   = 8;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned DIR_W   = 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_POSITION  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWNHILL_FRAMES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_MARGIN     = 3'd4;

  // Register reset values
  localparam logic [STEP_W-1:0]  STEP_SIZE_RST       = 10'd10;
  localparam logic [POS_W-1:0]   START_POSITION_RST  = 12'd1000;
  localparam logic [POS_W-1:0]   TRAVEL_LIMIT_RST    = 12'd2048;
  localparam logic [DHF_W-1:0]   DOWNHILL_FRAMES_RST = 8'd3;
  localparam logic [SHARP_W-1:0] RATE_MARGIN_RST     = 16'd0;

  // Stream widths, padded to whole bytes
  localparam int unsigned S_DATA_W = ((SHARP_W + 7) / 8) * 8;
  localparam int unsigned RES_W    = STAT_W + DIR_W + CNT_W + 2 * POS_W + SHARP_W;
  localparam int unsigned M_DATA_W = ((RES_W + 7) / 8) * 8;

  // Saturation limits
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [DHF_W-1:0] DHC_MAX = {DHF_W{1'b1}};

  // Result codes
  localparam logic [STAT_W-1:0] STATUS_SCANNING  = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_CONVERGED = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_LIMIT     = 2'd2;
  localparam logic [DIR_W-1:0]  DIR_FORWARD      = 2'b01;
  localparam logic [DIR_W-1:0]  DIR_BACKWARD     = 2'b11;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_SCANNING  = 2'd1,
    MODE_CONVERGED = 2'd2,
    MODE_LIMIT     = 2'd3
  } mode_t;

  typedef struct packed {
    logic [STEP_W-1:0]  step_size;
    logic [POS_W-1:0]   start_position;
    logic [POS_W-1:0]   travel_limit;
    logic [DHF_W-1:0]   downhill_frames;
    logic [SHARP_W-1:0] rate_margin;
  } cfg_t;

  typedef struct packed {
    mode_t              mode;
    logic [CNT_W-1:0]   step_count;
    logic               dir_neg;
    logic [SHARP_W-1:0] peak_rate;
    logic [SHARP_W-1:0] prev_rate;
    logic [DHF_W-1:0]   downhill_count;
    logic               peak_seen;
    logic [CNT_W-1:0]   frame_index;
    logic [CNT_W-1:0]   peak_frame;
    logic [POS_W-1:0]   position;
    logic [POS_W-1:0]   peak_position;
  } search_state_t;

  typedef struct packed {
    logic [SHARP_W-1:0] peak_sharpness;
    logic [POS_W-1:0]   best_position;
    logic [POS_W-1:0]   lens_position;
    logic [CNT_W-1:0]   move_steps;
    logic [DIR_W-1:0]   move_dir;
    logic [STAT_W-1:0]  search_status;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/hcf_step.sv */
`default_nettype none

module hcf_step (
  input  wire hcf_pkg::cfg_t                  cfg,
  input  wire hcf_pkg::search_state_t         st,
  input  wire logic [hcf_pkg::SHARP_W-1:0]    rate,
  output hcf_pkg::search_state_t              st_next
);
  import hcf_pkg::*;

  localparam int unsigned SUM_W  = SHARP_W + 1;
  localparam int unsigned NEXT_W = CNT_W + 2;
  localparam int unsigned PROD_W = CNT_W + STEP_W;

  always_comb begin
    search_state_t       s;
    logic [SUM_W-1:0]    peak_sum;
    logic [SUM_W-1:0]    rate_sum;
    logic [SHARP_W-1:0]  floor_rate;
    logic [CNT_W-1:0]    frames;
    logic [PROD_W-1:0]   product;
    logic [NEXT_W-1:0]   pos_ext;
    logic [NEXT_W-1:0]   step_ext;
    logic [NEXT_W-1:0]   target_pos;
    logic                done;

    s = st;

    // first frame starts the search
    if (s.mode == MODE_IDLE) begin
      s.mode           = MODE_SCANNING;
      s.step_count     = CNT_W'(cfg.step_size);
      s.dir_neg        = 1'b0;
      s.peak_rate      = '0;
      s.downhill_count = '0;
      s.peak_seen      = 1'b0;
      s.frame_index    = '0;
      s.position       = cfg.start_position;
      s.peak_position  = cfg.start_position;
    end

    if (s.frame_index != CNT_MAX) begin
      s.frame_index = s.frame_index + 1'b1;
    end

    // new peak: empty peak or clear of the margin
    peak_sum = {1'b0, s.peak_rate} + {1'b0, cfg.rate_margin};
    if (s.peak_rate == '0 || {1'b0, rate} > peak_sum) begin
      s.peak_rate      = rate;
      s.peak_frame     = s.frame_index;
      s.peak_position  = s.position;
      s.peak_seen      = 1'b1;
      s.downhill_count = '0;
      s.prev_rate      = rate;
    end

    floor_rate = '0;
    frames     = '0;
    product    = '0;
    done       = 1'b0;
    if (s.peak_seen) begin
      floor_rate = (s.peak_rate > cfg.rate_margin) ? (s.peak_rate - cfg.rate_margin) : '0;
      if (rate < floor_rate && s.downhill_count != DHC_MAX) begin
        s.downhill_count = s.downhill_count + 1'b1;
      end
      if (s.downhill_count >= cfg.downhill_frames) begin
        frames       = (s.frame_index >= s.peak_frame) ? (s.frame_index - s.peak_frame) : '0;
        product      = PROD_W'(frames) * PROD_W'(cfg.step_size);
        s.mode       = MODE_CONVERGED;
        s.dir_neg    = 1'b1;
        s.step_count = (product > PROD_W'(CNT_MAX)) ? CNT_MAX : product[CNT_W-1:0];
        done         = 1'b1;
      end
    end

    rate_sum   = {1'b0, rate} + {1'b0, cfg.rate_margin};
    pos_ext    = NEXT_W'(s.position);
    step_ext   = NEXT_W'(s.step_count);
    target_pos = '0;
    if (!done) begin
      if (!s.peak_seen && rate_sum < {1'b0, s.prev_rate}) begin
        s.dir_neg = !s.dir_neg;
      end
      target_pos = s.dir_neg ? (pos_ext - step_ext) : (pos_ext + step_ext);
      if (target_pos[NEXT_W-1] || target_pos > NEXT_W'(cfg.travel_limit)) begin
        s.mode = MODE_LIMIT;
        if (s.peak_position > s.position) begin
          s.step_count = CNT_W'(s.peak_position - s.position);
          s.dir_neg    = 1'b0;
        end else begin
          s.step_count = CNT_W'(s.position - s.peak_position);
          s.dir_neg    = 1'b1;
        end
      end else begin
        s.position  = target_pos[POS_W-1:0];
        s.prev_rate = rate;
      end
    end

    st_next = s;
  end

endmodule

`default_nettype wire

/* hw/rtl/hill_climb_focus_controller.sv */
`default_nettype none

// Hill-climbing autofocus controller. Feed one frame sharpness score per
// frame on the slave stream; each transfer yields exactly one result on the
// master stream with the search status (scanning, converged, reached travel
// limit), the motor move to make (direction and step count), the lens
// position recorded after the frame, and the best position with its peak
// sharpness. The first frame after reset starts the search from
// start_position, moving forward by step_size. Once downhill_frames scores
// since the peak fall below (peak - rate_margin), it reports converged with a
// backward move of step_size per frame since the peak; a scan move that
// would leave 0..travel_limit reports the move back to the best position.
// Only reset returns the search to idle. Throughput is one frame per clock
// while the master side takes results: a score is registered in the input
// register on transfer, the per-frame update runs on it combinationally,
// and the result register captures it when it moves on. A stalled master
// side backs up through the result register into the input register.
// Write the configuration registers only while no frame is in flight.
module hill_climb_focus_controller (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration write port
  input  wire logic                              cfg_wr_en,
  input  wire logic [hcf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [hcf_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
  // sharpness stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [hcf_pkg::S_DATA_W-1:0]      s_tdata,  // [15:0] frame_sharpness
  // result stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [1:0] search_status, [3:2] move_dir, [19:4] move_steps, [31:20] lens_position,
  // [43:32] best_position, [59:44] peak_sharpness, rest zero
  output logic [hcf_pkg::M_DATA_W-1:0]           m_tdata
);
  import hcf_pkg::*;

  cfg_t                cfg;
  search_state_t       st;
  search_state_t       st_next;
  logic                stage_valid;
  logic [SHARP_W-1:0]  stage_rate;
  logic                advance;
  result_t             result;
  result_t             result_next;

  // Configuration registers; out-of-range indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_size       <= STEP_SIZE_RST;
      cfg.start_position  <= START_POSITION_RST;
      cfg.travel_limit    <= TRAVEL_LIMIT_RST;
      cfg.downhill_frames <= DOWNHILL_FRAMES_RST;
      cfg.rate_margin     <= RATE_MARGIN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_STEP_SIZE:       cfg.step_size       <= cfg_wr_data[STEP_W-1:0];
        CFG_START_POSITION:  cfg.start_position  <= cfg_wr_data[POS_W-1:0];
        CFG_TRAVEL_LIMIT:    cfg.travel_limit    <= cfg_wr_data[POS_W-1:0];
        CFG_DOWNHILL_FRAMES: cfg.downhill_frames <= cfg_wr_data[DHF_W-1:0];
        CFG_RATE_MARGIN:     cfg.rate_margin     <= cfg_wr_data[SHARP_W-1:0];
        default: ;
      endcase
    end
  end

  // The result register moves on when empty or being taken; the input
  // register refills whenever it is empty or drains into the result.
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tready) begin
      stage_valid <= s_tvalid;
    end
  end

  // Hold the score until it is consumed.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stage_rate <= s_tdata[SHARP_W-1:0];
    end
  end

  hcf_step u_step (
    .cfg     (cfg),
    .st      (st),
    .rate    (stage_rate),
    .st_next (st_next)
  );

  // Advance the search state once per consumed frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode           <= MODE_IDLE;
      st.step_count     <= '0;
      st.dir_neg        <= 1'b0;
      st.peak_rate      <= '0;
      st.prev_rate      <= '0;
      st.downhill_count <= '0;
      st.peak_seen      <= 1'b0;
      st.frame_index    <= '0;
      st.peak_frame     <= '0;
      st.position       <= '0;
      st.peak_position  <= '0;
    end else if (stage_valid && advance) begin
      st <= st_next;
    end
  end

  // Map the updated state onto the result fields.
  always_comb begin
    result_next.peak_sharpness = st_next.peak_rate;
    result_next.best_position  = st_next.peak_position;
    result_next.lens_position  = st_next.position;
    result_next.move_steps     = st_next.step_count;
    result_next.move_dir       = st_next.dir_neg ? DIR_BACKWARD : DIR_FORWARD;
    case (st_next.mode)
      MODE_CONVERGED: result_next.search_status = STATUS_CONVERGED;
      MODE_LIMIT:     result_next.search_status = STATUS_LIMIT;
      default:        result_next.search_status = STATUS_SCANNING;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid && advance) begin
      result <= result_next;
    end
  end

  assign m_tdata = M_DATA_W'(result);

  // A stalled frame in the input register stays put.
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |=> stage_valid && $stable(stage_rate))
    else $error("input register lost or changed a stalled frame");

  // Every consumed frame shows up in the result register.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    stage_valid && advance |=> m_tvalid)
    else $error("consumed frame produced no result");

  // The search never falls back to idle once a frame went through.
  a_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    stage_valid && advance |=> st.mode != MODE_IDLE)
    else $error("search returned to idle");

  // No result can exist before the search has started.
  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    st.mode == MODE_IDLE |-> !m_tvalid)
    else $error("result presented while idle");

  // Convergence always backs off toward the peak.
  a_converged_backward: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result.search_status == STATUS_CONVERGED |-> result.move_dir == DIR_BACKWARD)
    else $error("converged result with forward move");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import hcf_pkg::*;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
  // Cycles the receiver refuses results during the back-pressure phase.
  localparam int HOLD_CYCLES = 80;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata = '0;  // [15:0] frame_sharpness
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [1:0] search_status, [3:2] move_dir, [19:4] move_steps, [31:20] lens_position,
  // [43:32] best_position, [59:44] peak_sharpness, rest zero
  logic [M_DATA_W-1:0]   m_tdata;

  hill_climb_focus_controller u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  // Register copies as the block should hold them
  logic [STEP_W-1:0]  cur_step   = STEP_SIZE_RST;
  logic [POS_W-1:0]   cur_start  = START_POSITION_RST;
  logic [POS_W-1:0]   cur_limit  = TRAVEL_LIMIT_RST;
  logic [DHF_W-1:0]   cur_dhf    = DOWNHILL_FRAMES_RST;
  logic [SHARP_W-1:0] cur_margin = RATE_MARGIN_RST;

  // Search state of the predictor
  mode_t              st_mode = MODE_IDLE;
  logic [CNT_W-1:0]   st_step = '0;
  logic               st_neg = 1'b0;
  logic [SHARP_W-1:0] st_peak = '0;
  logic [SHARP_W-1:0] st_prev = '0;
  logic [DHF_W-1:0]   st_dhc = '0;
  logic               st_seen = 1'b0;
  logic [CNT_W-1:0]   st_frame = '0;
  logic [CNT_W-1:0]   st_peak_frame = '0;
  logic [POS_W-1:0]   st_pos = '0;
  logic [POS_W-1:0]   st_peak_pos = '0;

  logic [S_DATA_W-1:0] pending_frames[$];
  result_t             expected_moves[$];

  int  mismatch_count = 0;
  int  frames_sent = 0;
  int  settings_used = 0;
  int  n_scan = 0, n_conv = 0, n_limit = 0;
  int  ceiling = 0;       // rising sharpness level for the hill generator
  bit  quiet = 1'b0;      // no idling on either side while set
  bit  hold_req = 1'b0;   // ask the receiver for one long hold-off
  int  tx_gap = 0;
  int  rx_stall = 0;
  int  hold_left = 0;
  result_t got, want;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

  // Idle length: mostly none, sometimes a few cycles, rarely a long stretch
  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (quiet || p < 60) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the search by one frame and queue the result it must produce
  task automatic predict_frame(input logic [SHARP_W-1:0] rate);
    logic [SHARP_W:0]   peak_plus;
    logic [SHARP_W:0]   rate_plus;
    logic [SHARP_W-1:0] floor_rate;
    logic [CNT_W-1:0]   frames;
    logic [25:0]        backoff;
    int                 target_pos;
    bit                 settled;
    result_t            r;
    settled = 1'b0;
    // First frame after reset starts the search
    if (st_mode == MODE_IDLE) begin
      st_mode     = MODE_SCANNING;
      st_step     = CNT_W'(cur_step);
      st_neg      = 1'b0;
      st_peak     = '0;
      st_dhc      = '0;
      st_seen     = 1'b0;
      st_frame    = '0;
      st_pos      = cur_start;
      st_peak_pos = cur_start;
    end
    if (st_frame != CNT_MAX) st_frame = st_frame + 1'b1;
    // New peak: nothing recorded yet, or clearly above the old peak
    peak_plus = {1'b0, st_peak} + {1'b0, cur_margin};
    if (st_peak == '0 || {1'b0, rate} > peak_plus) begin
      st_peak       = rate;
      st_peak_frame = st_frame;
      st_peak_pos   = st_pos;
      st_seen       = 1'b1;
      st_dhc        = '0;
      st_prev       = rate;
    end
    if (st_seen) begin
      floor_rate = (st_peak > cur_margin) ? st_peak - cur_margin : '0;
      if (rate < floor_rate && st_dhc != DHC_MAX) st_dhc = st_dhc + 1'b1;
      // Enough frames downhill: back off toward the peak
      if (st_dhc >= cur_dhf) begin
        frames  = (st_frame >= st_peak_frame) ? st_frame - st_peak_frame : '0;
        backoff = 26'(frames) * 26'(cur_step);
        st_mode = MODE_CONVERGED;
        st_neg  = 1'b1;
        st_step = (backoff > 26'(CNT_MAX)) ? CNT_MAX : backoff[CNT_W-1:0];
        settled = 1'b1;
      end
    end
    if (!settled) begin
      // Reversal before any peak; kept though a first frame always peaks
      rate_plus = {1'b0, rate} + {1'b0, cur_margin};
      if (!st_seen && rate_plus < {1'b0, st_prev}) st_neg = ~st_neg;
      target_pos = int'(st_pos);
      if (st_neg) target_pos = target_pos - int'(st_step);
      else target_pos = target_pos + int'(st_step);
      if (target_pos < 0 || target_pos > int'(cur_limit)) begin
        // Out of travel: report the move back to the best position
        st_mode = MODE_LIMIT;
        if (st_peak_pos > st_pos) begin
          st_step = CNT_W'(st_peak_pos - st_pos);
          st_neg  = 1'b0;
        end else begin
          st_step = CNT_W'(st_pos - st_peak_pos);
          st_neg  = 1'b1;
        end
      end else begin
        st_pos  = target_pos[POS_W-1:0];
        st_prev = rate;
      end
    end
    case (st_mode)
      MODE_CONVERGED: begin
        r.search_status = STATUS_CONVERGED;
        n_conv++;
      end
      MODE_LIMIT: begin
        r.search_status = STATUS_LIMIT;
        n_limit++;
      end
      default: begin
        r.search_status = STATUS_SCANNING;
        n_scan++;
      end
    endcase
    r.move_dir       = st_neg ? DIR_BACKWARD : DIR_FORWARD;
    r.move_steps     = st_step;
    r.lens_position  = st_pos;
    r.best_position  = st_peak_pos;
    r.peak_sharpness = st_peak;
    expected_moves.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      $display("%0t ns: %s expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Sender: offer queued frames, predict each one on its transfer
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_frame(s_tdata);
        frames_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_frames.size() > 0) begin
          s_tdata  <= pending_frames.pop_front();
          s_tvalid <= 1'b1;
          tx_gap = idle_len();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare each result with the oldest expectation, stall at random
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[RES_W-1:0];
        if (expected_moves.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: result with none expected, actual %h", $time, m_tdata);
        end else begin
          want = expected_moves.pop_front();
          check_field("search_status", 16'(want.search_status), 16'(got.search_status));
          check_field("move_dir", 16'(want.move_dir), 16'(got.move_dir));
          check_field("move_steps", want.move_steps, got.move_steps);
          check_field("lens_position", 16'(want.lens_position), 16'(got.lens_position));
          check_field("best_position", 16'(want.best_position), 16'(got.best_position));
          check_field("peak_sharpness", want.peak_sharpness, got.peak_sharpness);
          check_field("padding", '0, 16'(m_tdata[M_DATA_W-1:RES_W]));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_req) begin
        // Long hold-off: let the block fill and stall its input
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        rx_stall = idle_len();
        m_tready <= (rx_stall == 0);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Write one register; the block must be idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    case (idx)
      CFG_STEP_SIZE:       cur_step   = val[STEP_W-1:0];
      CFG_START_POSITION:  cur_start  = val[POS_W-1:0];
      CFG_TRAVEL_LIMIT:    cur_limit  = val[POS_W-1:0];
      CFG_DOWNHILL_FRAMES: cur_dhf    = val[DHF_W-1:0];
      CFG_RATE_MARGIN:     cur_margin = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Wait until every queued frame is sent and every result is back
  task automatic drain();
    do @(negedge clk);
    while (pending_frames.size() != 0 || s_tvalid || expected_moves.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Pick a full setting, extremes weighted in
  task automatic random_settings();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = 0;
      1: v = 1;
      2: v = 1023;
      default: v = CFG_DATA_W'($urandom_range(1, 40));
    endcase
    write_reg(CFG_STEP_SIZE, v);
    case ($urandom_range(0, 3))
      0: v = 0;
      1: v = 4095;
      default: v = CFG_DATA_W'($urandom_range(0, 4095));
    endcase
    write_reg(CFG_TRAVEL_LIMIT, v);
    case ($urandom_range(0, 4))
      0: v = 0;
      1: v = 1;
      2: v = 255;
      default: v = CFG_DATA_W'($urandom_range(1, 6));
    endcase
    write_reg(CFG_DOWNHILL_FRAMES, v);
    case ($urandom_range(0, 4))
      0: v = 0;
      1: v = 65535;
      default: v = CFG_DATA_W'($urandom_range(0, 300));
    endcase
    write_reg(CFG_RATE_MARGIN, v);
    write_reg(CFG_START_POSITION, CFG_DATA_W'($urandom_range(0, 4095)));
    if ($urandom_range(0, 3) == 0) begin
      write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom_range(0, 65535)));
    end
    settings_used++;
  endtask

  // Mostly hill-shaped runs that climb above the last peak, some noise
  task automatic queue_hills(input int n);
    int len, k, offset, v;
    while (n > 0) begin
      if ($urandom_range(0, 6) == 0) begin
        pending_frames.push_back(S_DATA_W'($urandom_range(0, ceiling)));
        n--;
      end else begin
        len = $urandom_range(3, 16);
        ceiling = ceiling + $urandom_range(1, 600);
        if (ceiling > 65534) ceiling = 65534;
        for (k = 0; k < len && n > 0; k++) begin
          offset = (k > len / 2) ? k - len / 2 : len / 2 - k;
          v = ceiling - offset * $urandom_range(20, 400);
          if (v < 0) v = 0;
          pending_frames.push_back(S_DATA_W'(v));
          n--;
        end
      end
    end
  endtask

  initial begin
    logic [S_DATA_W-1:0] warmup[14] = '{0, 0, 500, 800, 1200, 1100, 1000, 900, 850,
                                        1300, 1301, 1299, 1000, 900};
    logic [S_DATA_W-1:0] wide[3]    = '{2000, 1000, 3000};
    logic [S_DATA_W-1:0] tight[5]   = '{1400, 1450, 1550, 1500, 1601};
    logic [S_DATA_W-1:0] still[4]   = '{1700, 1650, 1800, 1750};
    int ph, k;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: peak at zero, climb, fall off, converge, climb again
    settings_used++;
    @(negedge clk);
    foreach (warmup[k]) pending_frames.push_back(warmup[k]);
    drain();

    // Zero downhill frames, widest margin, largest step and travel
    write_reg(CFG_DOWNHILL_FRAMES, 0);
    write_reg(CFG_RATE_MARGIN, 65535);
    write_reg(CFG_STEP_SIZE, 1023);
    write_reg(CFG_TRAVEL_LIMIT, 4095);
    write_reg(CFG_START_POSITION, 4095);
    write_reg(CFG_UNMAPPED, 16'hFFFF);
    settings_used++;
    @(negedge clk);
    foreach (wide[k]) pending_frames.push_back(wide[k]);
    drain();

    // No travel at all, saturating downhill requirement
    write_reg(CFG_RATE_MARGIN, 100);
    write_reg(CFG_DOWNHILL_FRAMES, 255);
    write_reg(CFG_TRAVEL_LIMIT, 0);
    settings_used++;
    @(negedge clk);
    foreach (tight[k]) pending_frames.push_back(tight[k]);
    drain();

    // Zero step size for the back-off product
    write_reg(CFG_STEP_SIZE, 0);
    write_reg(CFG_TRAVEL_LIMIT, 2048);
    write_reg(CFG_DOWNHILL_FRAMES, 1);
    write_reg(CFG_RATE_MARGIN, 0);
    settings_used++;
    @(negedge clk);
    foreach (still[k]) pending_frames.push_back(still[k]);
    drain();
    ceiling = 1800;

    for (ph = 0; ph < 12; ph++) begin
      random_settings();
      quiet = (ph == 3 || ph == 6);
      @(negedge clk);
      queue_hills(160);
      if (ph == 6) hold_req = 1'b1;
      drain();
      quiet = 1'b0;
    end

    // Top of the sharpness range, then anything at all
    write_reg(CFG_STEP_SIZE, 1023);
    write_reg(CFG_TRAVEL_LIMIT, 4095);
    write_reg(CFG_RATE_MARGIN, 0);
    write_reg(CFG_DOWNHILL_FRAMES, CFG_DATA_W'($urandom_range(1, 8)));
    settings_used++;
    @(negedge clk);
    pending_frames.push_back(16'hFFFF);
    pending_frames.push_back(16'h0000);
    for (k = 0; k < 20; k++) pending_frames.push_back(S_DATA_W'($urandom_range(0, 65535)));
    drain();
    repeat (10) @(negedge clk);

    $display("Checked %0d frames across %0d register settings.", frames_sent, settings_used);
    $display("Results: %0d scanning, %0d converged, %0d at travel limit.",
             n_scan, n_conv, n_limit);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* hill_climb_focus_controller.f */
hw/rtl/hcf_pkg.sv
hw/rtl/hcf_step.sv
hw/rtl/hill_climb_focus_controller.sv
tb/tb_top.sv
